// File: rtl/core/active_pf_to_apparent_cmd_core_assert.svh
// assertion macros for the core rtl, included by apac_back
`ifndef ACTIVE_PF_TO_APPARENT_CMD_CORE_ASSERT_SVH
`define ACTIVE_PF_TO_APPARENT_CMD_CORE_ASSERT_SVH

// same-cycle implication on clk, quiet during rst
`define APAC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication on clk, quiet during rst
`define APAC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/apac_pkg.sv
// shared constants for the active power / power factor to apparent command core
package apac_pkg;

  localparam int POWER_WIDTH_DEF  = 24;
  localparam int PF_FRAC_BITS_DEF = 15;
  localparam int QUEUE_DEPTH_DEF  = 4;

  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  localparam logic [1:0] REG_PF_FLOOR   = 2'd0;
  localparam logic [1:0] REG_PF_CEILING = 2'd1;
  localparam logic [1:0] REG_S_LIMIT    = 2'd2;

  localparam longint unsigned S_LIMIT_RST = 64'd2782000;

endpackage

// File: rtl/core/apac_regs.sv
// apb configuration registers: pf clamp bounds and apparent power limit
module apac_regs import apac_pkg::*; #(
  parameter int POWER_WIDTH  = POWER_WIDTH_DEF,
  parameter int PF_FRAC_BITS = PF_FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [APB_ADDR_W-1:0]  paddr,
  input  logic [APB_DATA_W-1:0]  pwdata,
  output logic [APB_DATA_W-1:0]  prdata,
  output logic                   pready,
  output logic [PF_FRAC_BITS-1:0] pf_floor,
  output logic [PF_FRAC_BITS-1:0] pf_ceiling,
  output logic [POWER_WIDTH-2:0]  s_limit
);

  localparam longint unsigned LIMIT_MAX = (64'd1 << (POWER_WIDTH - 1)) - 64'd1;
  localparam logic [PF_FRAC_BITS-1:0] FLOOR_RST =
    PF_FRAC_BITS'(((2 ** PF_FRAC_BITS) + 99) / 100);
  localparam logic [PF_FRAC_BITS-1:0] CEILING_RST = PF_FRAC_BITS'((2 ** PF_FRAC_BITS) - 3);
  localparam logic [POWER_WIDTH-2:0] LIMIT_RST =
    (POWER_WIDTH - 1)'((S_LIMIT_RST < LIMIT_MAX) ? S_LIMIT_RST : LIMIT_MAX);

  logic       wr_en;
  logic [1:0] reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      pf_floor   <= FLOOR_RST;
      pf_ceiling <= CEILING_RST;
      s_limit    <= LIMIT_RST;
    end else if (wr_en) begin
      case (reg_sel)
        REG_PF_FLOOR:   pf_floor   <= pwdata[PF_FRAC_BITS-1:0];
        REG_PF_CEILING: pf_ceiling <= pwdata[PF_FRAC_BITS-1:0];
        REG_S_LIMIT:    s_limit    <= pwdata[POWER_WIDTH-2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_PF_FLOOR:   prdata = APB_DATA_W'(pf_floor);
      REG_PF_CEILING: prdata = APB_DATA_W'(pf_ceiling);
      REG_S_LIMIT:    prdata = APB_DATA_W'(s_limit);
      default:        prdata = '0;
    endcase
  end

endmodule

// File: rtl/core/apac_front.sv
// front end: takes setpoints, splits sign and magnitude, clamps the pf magnitude
module apac_front import apac_pkg::*; #(
  parameter int POWER_WIDTH  = POWER_WIDTH_DEF,
  parameter int PF_FRAC_BITS = PF_FRAC_BITS_DEF,
  parameter int ENTRY_W      = POWER_WIDTH + PF_FRAC_BITS + 2
) (
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [POWER_WIDTH-1:0]  p_set,
  input  logic signed [PF_FRAC_BITS:0]   pf_set,
  input  logic [PF_FRAC_BITS-1:0]        pf_floor,
  input  logic [PF_FRAC_BITS-1:0]        pf_ceiling,
  input  logic                           q_full,
  output logic                           q_push,
  output logic [ENTRY_W-1:0]             q_entry
);

  logic                    p_neg;
  logic                    pf_neg;
  logic [POWER_WIDTH-1:0]  p_mag;
  logic [PF_FRAC_BITS:0]   pf_mag;
  logic [PF_FRAC_BITS-1:0] pf_abs;

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;

  assign p_neg  = p_set[POWER_WIDTH-1];
  assign pf_neg = pf_set[PF_FRAC_BITS];
  assign p_mag  = p_neg ? (~$unsigned(p_set) + 1'b1) : $unsigned(p_set);
  assign pf_mag = pf_neg ? (~$unsigned(pf_set) + 1'b1) : $unsigned(pf_set);

  always_comb begin
    if (pf_mag < {1'b0, pf_floor}) begin
      pf_abs = pf_floor;
    end else if (pf_mag > {1'b0, pf_ceiling}) begin
      pf_abs = pf_ceiling;
    end else begin
      pf_abs = pf_mag[PF_FRAC_BITS-1:0];
    end
  end

  assign q_entry = {pf_neg, p_neg, pf_abs, p_mag};

endmodule

// File: rtl/core/apac_queue.sv
// short fifo between the front end and the divider pipeline
module apac_queue import apac_pkg::*; #(
  parameter int WIDTH = POWER_WIDTH_DEF + PF_FRAC_BITS_DEF + 2,
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head,
  output logic             empty,
  output logic             full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [0:DEPTH-1];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_pop;

  assign empty  = (count == '0);
  assign full   = (count == CNT_W'(DEPTH));
  assign do_pop = pop && !empty;
  assign head   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: rtl/core/apac_back.sv
// back end: restoring divider pipeline, limit test and output register
`include "active_pf_to_apparent_cmd_core_assert.svh"
module apac_back import apac_pkg::*; #(
  parameter int POWER_WIDTH  = POWER_WIDTH_DEF,
  parameter int PF_FRAC_BITS = PF_FRAC_BITS_DEF,
  parameter int ENTRY_W      = POWER_WIDTH + PF_FRAC_BITS + 2
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [ENTRY_W-1:0]            q_head,
  input  logic                          q_empty,
  output logic                          q_pop,
  input  logic [POWER_WIDTH-2:0]        s_limit,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [POWER_WIDTH-1:0] s_cmd,
  output logic signed [PF_FRAC_BITS:0]  pf_cmd,
  output logic                          ok
);

  localparam int N  = POWER_WIDTH - 1;
  localparam int F  = PF_FRAC_BITS;
  localparam int DW = POWER_WIDTH + PF_FRAC_BITS;

  logic                   en;
  logic [POWER_WIDTH-1:0] in_p_mag;
  logic [F-1:0]           in_pf_abs;
  logic                   in_p_neg;
  logic                   in_pf_neg;
  logic [DW-1:0]          dividend;
  logic [F:0]             div_hi;
  logic                   in_ovf;

  logic         vld  [0:N];
  logic [F-1:0] rem  [0:N];
  logic [N-1:0] quo  [0:N];
  logic [N-1:0] dlo  [0:N];
  logic [F-1:0] dvs  [0:N];
  logic         pneg [0:N];
  logic         fneg [0:N];
  logic         ovf  [0:N];

  logic [F:0] trial [0:N-1];
  logic [F:0] diff  [0:N-1];
  logic       ge    [0:N-1];

  logic [POWER_WIDTH-1:0] s_ext;
  logic [F:0]             pf_ext;
  logic                   in_limit;

  assign en    = !out_valid || out_ready;
  assign q_pop = en && !q_empty;

  assign in_p_mag  = q_head[POWER_WIDTH-1:0];
  assign in_pf_abs = q_head[POWER_WIDTH+F-1:POWER_WIDTH];
  assign in_p_neg  = q_head[POWER_WIDTH+F];
  assign in_pf_neg = q_head[POWER_WIDTH+F+1];

  assign dividend = {in_p_mag, {F{1'b0}}};
  assign div_hi   = dividend[DW-1:N];
  assign in_ovf   = (in_pf_abs != '0) && (div_hi >= {1'b0, in_pf_abs});

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= q_pop;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= div_hi[F-1:0];
      quo[0]  <= '0;
      dlo[0]  <= dividend[N-1:0];
      dvs[0]  <= in_pf_abs;
      pneg[0] <= in_p_neg;
      fneg[0] <= in_pf_neg;
      ovf[0]  <= in_ovf;
    end
  end

  for (genvar j = 0; j < N; j++) begin : g_stage
    assign trial[j] = {rem[j], dlo[j][N-1]};
    assign diff[j]  = trial[j] - {1'b0, dvs[j]};
    assign ge[j]    = trial[j] >= {1'b0, dvs[j]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j+1] <= 1'b0;
      end else if (en) begin
        vld[j+1] <= vld[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[j+1]  <= ge[j] ? diff[j][F-1:0] : trial[j][F-1:0];
        quo[j+1]  <= {quo[j][N-2:0], ge[j]};
        dlo[j+1]  <= {dlo[j][N-2:0], 1'b0};
        dvs[j+1]  <= dvs[j];
        pneg[j+1] <= pneg[j];
        fneg[j+1] <= fneg[j];
        ovf[j+1]  <= ovf[j];
      end
    end
  end

  assign in_limit = !ovf[N] && (quo[N] <= s_limit);
  assign s_ext    = {1'b0, quo[N]};
  assign pf_ext   = {1'b0, dvs[N]};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[N];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ok     <= in_limit;
      s_cmd  <= !in_limit ? '0 : (fneg[N] ? (~s_ext + 1'b1) : s_ext);
      pf_cmd <= !in_limit ? '0 : (pneg[N] ? (~pf_ext + 1'b1) : pf_ext);
    end
  end

  `APAC_ASSERT_IMPL(a_reject_zero, out_valid && !ok, (s_cmd == '0) && (pf_cmd == '0),
    "rejected command with nonzero outputs")
  `APAC_ASSERT_IMPL(a_pf_range, out_valid && ok, pf_cmd != {1'b1, {F{1'b0}}},
    "power factor command out of range")
  `APAC_ASSERT_NEXT(a_drain, vld[N] && en, out_valid,
    "pipeline result not loaded into output register")

endmodule

// File: rtl/core/active_pf_to_apparent_cmd_core.sv
// path to output valid: fifo slot, divider stage 0, divider stages, output register
// throughput: one item per cycle while the output side takes a transfer each cycle
// the restoring divider resolves one quotient bit per pipeline stage, POWER_WIDTH-1 stages
// a four-entry fifo lets the input side keep going while the output side stalls, until it fills
// rst is synchronous: clears all valid bits and fifo pointers, loads register defaults
module active_pf_to_apparent_cmd_core import apac_pkg::*; #(
  parameter int POWER_WIDTH  = POWER_WIDTH_DEF,
  parameter int PF_FRAC_BITS = PF_FRAC_BITS_DEF,
  parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF,
  parameter int IN_TW        = ((POWER_WIDTH + PF_FRAC_BITS + 1 + 7) / 8) * 8,
  parameter int OUT_TW       = ((POWER_WIDTH + PF_FRAC_BITS + 1 + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_TW-1:0]      s_axis_tdata,   // p_set, pf_set, zero pad
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_TW-1:0]     m_axis_tdata,   // s_cmd, pf_cmd, zero pad
  output logic [0:0]            m_axis_tuser,   // ok
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int ENTRY_W = POWER_WIDTH + PF_FRAC_BITS + 2;

  logic [PF_FRAC_BITS-1:0]        pf_floor;
  logic [PF_FRAC_BITS-1:0]        pf_ceiling;
  logic [POWER_WIDTH-2:0]         s_limit;
  logic signed [POWER_WIDTH-1:0]  p_set;
  logic signed [PF_FRAC_BITS:0]   pf_set;
  logic                           q_push;
  logic                           q_pop;
  logic                           q_full;
  logic                           q_empty;
  logic [ENTRY_W-1:0]             q_entry;
  logic [ENTRY_W-1:0]             q_head;
  logic signed [POWER_WIDTH-1:0]  s_cmd;
  logic signed [PF_FRAC_BITS:0]   pf_cmd;
  logic                           ok;

  assign p_set  = s_axis_tdata[POWER_WIDTH-1:0];
  assign pf_set = s_axis_tdata[POWER_WIDTH+PF_FRAC_BITS:POWER_WIDTH];

  apac_regs #(
    .POWER_WIDTH  (POWER_WIDTH),
    .PF_FRAC_BITS (PF_FRAC_BITS)
  ) u_regs (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .pf_floor   (pf_floor),
    .pf_ceiling (pf_ceiling),
    .s_limit    (s_limit)
  );

  apac_front #(
    .POWER_WIDTH  (POWER_WIDTH),
    .PF_FRAC_BITS (PF_FRAC_BITS),
    .ENTRY_W      (ENTRY_W)
  ) u_front (
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .p_set      (p_set),
    .pf_set     (pf_set),
    .pf_floor   (pf_floor),
    .pf_ceiling (pf_ceiling),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_entry    (q_entry)
  );

  apac_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_entry),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty),
    .full      (q_full)
  );

  apac_back #(
    .POWER_WIDTH  (POWER_WIDTH),
    .PF_FRAC_BITS (PF_FRAC_BITS),
    .ENTRY_W      (ENTRY_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_head    (q_head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .s_limit   (s_limit),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .s_cmd     (s_cmd),
    .pf_cmd    (pf_cmd),
    .ok        (ok)
  );

  assign m_axis_tdata = OUT_TW'({pf_cmd, s_cmd});
  assign m_axis_tuser = ok;

endmodule

// File: bench/testbench.sv
// self-checking bench for the active power / power factor to apparent command core
module testbench;
  import apac_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PW = POWER_WIDTH_DEF;
  localparam int PFB = PF_FRAC_BITS_DEF;
  localparam int PFW = PFB + 1;
  localparam int TW = ((PW + PFW + 7) / 8) * 8;
  localparam int SEG_ITEMS = 240;
  localparam int TAIL_CYCLES = 40;
  localparam int LIMIT_CYCLES = 400000;
  localparam longint unsigned P_MAXMAG = (64'd1 << (PW - 1)) - 1;

  typedef struct {
    logic [PW-1:0]  p;
    logic [PFW-1:0] pf;
  } setpoint_t;

  typedef struct {
    logic [PW-1:0]  s_cmd;
    logic [PFW-1:0] pf_cmd;
    logic           ok;
  } apparent_cmd_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [TW-1:0] s_axis_tdata = '0;  // p_set, pf_set, zero pad
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [TW-1:0] m_axis_tdata;       // s_cmd, pf_cmd, zero pad
  logic [0:0] m_axis_tuser;          // ok
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  logic [PFB-1:0] cfg_floor = 15'd328;
  logic [PFB-1:0] cfg_ceiling = 15'd32765;
  logic [PW-2:0]  cfg_limit = 23'(S_LIMIT_RST);

  setpoint_t setpoint_queue[$];
  apparent_cmd_t cmd_expected[$];
  int send_idle_pct = 14;
  int recv_idle_pct = 83;
  int error_count = 0;
  int cycle_count = 0;

  active_pf_to_apparent_cmd_core DUT (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready), .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic longint unsigned mag_of(logic [63:0] raw, int width);
    longint unsigned v;
    v = raw & ((64'd1 << width) - 1);
    return v[width-1] ? (64'd1 << width) - v : v;
  endfunction

  function automatic longint unsigned clamped_pf(logic [PFW-1:0] pf);
    longint unsigned m;
    m = mag_of(64'(pf), PFW);
    if (m < cfg_floor) return cfg_floor;
    if (m > cfg_ceiling) return cfg_ceiling;
    return m;
  endfunction

  function automatic apparent_cmd_t apparent_cmd_of(setpoint_t sp);
    longint unsigned p_mag, pf_abs, s_abs;
    apparent_cmd_t r;
    p_mag = mag_of(64'(sp.p), PW);
    pf_abs = clamped_pf(sp.pf);
    s_abs = (pf_abs == 0) ? P_MAXMAG : (p_mag << PFB) / pf_abs;
    if (s_abs > cfg_limit) begin
      r.s_cmd = '0;
      r.pf_cmd = '0;
      r.ok = 1'b0;
    end else begin
      r.s_cmd = sp.pf[PFW-1] ? PW'(64'd0 - s_abs) : PW'(s_abs);
      r.pf_cmd = sp.p[PW-1] ? PFW'(64'd0 - pf_abs) : PFW'(pf_abs);
      r.ok = 1'b1;
    end
    return r;
  endfunction

  // mix of full-range noise, moderate, near-limit, zero and full-scale setpoints
  function automatic setpoint_t random_setpoint();
    setpoint_t sp;
    longint unsigned mag;
    logic neg;
    neg = 1'($urandom);
    if ($urandom_range(7) == 0) begin
      case ($urandom_range(5))
        0: sp.pf = '0;
        1: sp.pf = 16'h7fff;
        2: sp.pf = 16'h8000;
        3: sp.pf = 16'hffff;
        4: sp.pf = {1'b0, cfg_floor};
        default: sp.pf = {1'($urandom), cfg_ceiling};
      endcase
    end else begin
      sp.pf = PFW'($urandom);
    end
    case ($urandom_range(5))
      0, 1: begin
        sp.p = PW'($urandom);
        return sp;
      end
      2: mag = $urandom_range(0, 3000000);
      3, 4: begin
        mag = (longint'(cfg_limit) * clamped_pf(sp.pf)) >> PFB;
        mag = mag + $urandom_range(0, 4);
        mag = (mag < 2) ? 0 : mag - 2;
      end
      default: mag = ($urandom_range(1) == 0) ? 0 : P_MAXMAG + 1;
    endcase
    if (!neg && mag > P_MAXMAG) mag = P_MAXMAG;
    if (mag > P_MAXMAG + 1) mag = P_MAXMAG + 1;
    sp.p = neg ? PW'(64'd0 - mag) : PW'(mag);
    return sp;
  endfunction

  task automatic queue_setpoint(input logic [PW-1:0] p, input logic [PFW-1:0] pf);
    setpoint_t sp;
    sp.p = p;
    sp.pf = pf;
    setpoint_queue.push_back(sp);
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (error_count < 40)
      $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycle_count);
    error_count++;
  endtask

  task automatic program_limits(input logic [PFB-1:0] floor_v, input logic [PFB-1:0] ceil_v,
                                input logic [PW-2:0] limit_v);
    logic [APB_DATA_W-1:0] vals[3];
    logic [1:0] regs[3];
    vals = '{APB_DATA_W'(floor_v), APB_DATA_W'(ceil_v), APB_DATA_W'(limit_v)};
    regs = '{REG_PF_FLOOR, REG_PF_CEILING, REG_S_LIMIT};
    for (int i = 0; i < 3; i++) begin
      @(posedge clk);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= APB_ADDR_W'({regs[i], 2'b00});
      pwdata <= vals[i];
      @(posedge clk);
      penable <= 1'b1;
    end
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    cfg_floor = floor_v;
    cfg_ceiling = ceil_v;
    cfg_limit = limit_v;
  endtask

  task automatic drain();
    @(negedge clk);
    while (setpoint_queue.size() != 0 || s_axis_tvalid || cmd_expected.size() != 0)
      @(negedge clk);
  endtask

  // input side: hold each setpoint until its transfer
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        cmd_expected.push_back(apparent_cmd_of('{s_axis_tdata[PW-1:0],
                                                 s_axis_tdata[PW+PFW-1:PW]}));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (setpoint_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          setpoint_t sp;
          sp = setpoint_queue.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= TW'({sp.pf, sp.p});
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // output side: random back-pressure and field-by-field compare
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (cmd_expected.size() == 0) begin
          report_mismatch("unexpected result", 64'(m_axis_tdata), 64'(m_axis_tuser));
        end else begin
          apparent_cmd_t want;
          want = cmd_expected.pop_front();
          if (m_axis_tdata[PW-1:0] !== want.s_cmd)
            report_mismatch("s_cmd", 64'(m_axis_tdata[PW-1:0]), 64'(want.s_cmd));
          if (m_axis_tdata[PW+PFW-1:PW] !== want.pf_cmd)
            report_mismatch("pf_cmd", 64'(m_axis_tdata[PW+PFW-1:PW]), 64'(want.pf_cmd));
          if (m_axis_tuser[0] !== want.ok)
            report_mismatch("ok", 64'(m_axis_tuser[0]), 64'(want.ok));
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("testbench: errors");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset limits: zero power, rejections, exact limit, clamping at both bounds
    queue_setpoint(24'd0, 16'd0);
    queue_setpoint(24'h7fffff, 16'h7fff);
    queue_setpoint(24'h800000, 16'h8000);
    queue_setpoint(24'd1000, 16'h7fff);
    queue_setpoint(-24'sd1000, 16'hc000);
    queue_setpoint(24'd1391000, 16'h4000);
    queue_setpoint(24'd1391001, 16'h4000);
    queue_setpoint(-24'sd1391000, 16'hc000);
    queue_setpoint(24'd100, 16'd1);
    queue_setpoint(-24'sd7, 16'd32766);
    queue_setpoint(24'hffffff, 16'hffff);
    drain();

    // zero divisor saturates the quotient
    program_limits(15'd0, 15'd0, 23'h7fffff);
    queue_setpoint(24'd0, 16'd0);
    queue_setpoint(-24'sd5, -16'sd3);
    queue_setpoint(24'h7fffff, 16'h8000);
    queue_setpoint(24'h800000, 16'd0);
    drain();

    // crossed bounds
    program_limits(15'd20000, 15'd10000, 23'h7fffff);
    queue_setpoint(24'd3000, 16'd5000);
    queue_setpoint(24'd3000, 16'd15000);
    queue_setpoint(-24'sd3000, 16'd25000);
    queue_setpoint(24'd3000, 16'h8000);
    drain();

    // zero limit passes only zero power
    program_limits(15'h7fff, 15'h7fff, 23'd0);
    queue_setpoint(24'd0, 16'd1234);
    queue_setpoint(24'd1, 16'h7fff);
    queue_setpoint(-24'sd1, -16'sd32767);
    drain();

    for (int seg = 0; seg < 6; seg++) begin
      if (seg < 2) begin
        send_idle_pct = 14;
        recv_idle_pct = 83;
      end else if (seg < 4) begin
        send_idle_pct = 83;
        recv_idle_pct = 14;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (seg)
        0: program_limits(15'd328, 15'd32765, 23'd2782000);
        1: program_limits(15'd0, 15'h7fff, 23'h7fffff);
        2: program_limits(15'($urandom_range(0, 2000)), 15'($urandom_range(20000, 32767)),
                          23'($urandom));
        3: program_limits(15'($urandom_range(16384, 32767)), 15'($urandom_range(0, 16383)),
                          23'($urandom));
        4: program_limits(15'($urandom), 15'($urandom), 23'($urandom));
        default: program_limits(15'd328, 15'd32765, 23'd2782000);
      endcase
      @(negedge clk);
      repeat (SEG_ITEMS) setpoint_queue.push_back(random_setpoint());
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end
endmodule

// File: files.f
+incdir+rtl/core
rtl/core/apac_pkg.sv
rtl/core/apac_regs.sv
rtl/core/apac_front.sv
rtl/core/apac_queue.sv
rtl/core/apac_back.sv
rtl/core/active_pf_to_apparent_cmd_core.sv
bench/testbench.sv
